FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the quadratic root solver.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`endif

FILE: hw/rtl/qrs_pkg.sv
// Package of the quadratic root solver: widths, status codes and stage types.
// Depends on nothing.
package qrs_pkg;

    localparam int SqrtSteps = 41;
    localparam int DivSteps  = 34;

    localparam logic [1:0] KindNotQuad = 2'd0;
    localparam logic [1:0] KindNoReal  = 2'd1;
    localparam logic [1:0] KindSingle  = 2'd2;
    localparam logic [1:0] KindTwo     = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [15:0]  quad;
        logic signed [15:0]  lin;
    } side_t;

    typedef struct packed {
        logic [42:0] rem;
        logic [40:0] root;
        logic [33:0] dsh;
        side_t       side;
    } sqrt_t;

    typedef struct packed {
        logic [24:0] rem;
        logic [33:0] low;
        logic [33:0] quo;
        logic        neg;
    } lane_t;

    typedef struct packed {
        lane_t       lp;
        lane_t       lm;
        logic [24:0] divisor;
        logic [1:0]  kind;
    } div_t;

endpackage

FILE: hw/rtl/qrs_in_if.sv
// Request channel carrying the three coefficients.
// Depends on nothing.
interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coef_quad;
    logic signed [15:0] coef_lin;
    logic signed [15:0] coef_const;

    modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
    modport sink   (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

FILE: hw/rtl/qrs_out_if.sv
// Result channel carrying the status and the two roots.
// Depends on nothing.
interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         root_kind;
    logic signed [39:0] root_plus;
    logic signed [39:0] root_minus;

    modport source (output valid, root_kind, root_plus, root_minus, input ready);
    modport sink   (input valid, root_kind, root_plus, root_minus, output ready);
endinterface

FILE: hw/rtl/qrs_sqrt_pipe.sv
// Pipelined digit-by-digit square root, one result bit per register stage.
// Depends on qrs_pkg.
module qrs_sqrt_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  qrs_pkg::sqrt_t in_data,
    output logic           out_valid,
    output qrs_pkg::sqrt_t out_data
);

    qrs_pkg::sqrt_t data_reg [1:qrs_pkg::SqrtSteps];
    logic           vld_reg  [1:qrs_pkg::SqrtSteps];
    qrs_pkg::sqrt_t cur      [0:qrs_pkg::SqrtSteps-1];
    logic           cur_vld  [0:qrs_pkg::SqrtSteps-1];

    for (genvar k = 0; k < qrs_pkg::SqrtSteps; k++)
    begin : g_step
        logic [44:0]    r2;
        logic [44:0]    trial;
        logic [44:0]    diff;
        logic           ge;
        qrs_pkg::sqrt_t data_next;

        if (k == 0)
        begin : g_first
            assign cur[k]     = in_data;
            assign cur_vld[k] = in_valid;
        end
        else
        begin : g_rest
            assign cur[k]     = data_reg[k];
            assign cur_vld[k] = vld_reg[k];
        end

        always_comb
        begin
            r2    = {cur[k].rem, cur[k].dsh[33:32]};
            trial = {2'b00, cur[k].root, 2'b01};
            diff  = r2 - trial;
            ge    = (r2 >= trial);
            data_next      = cur[k];
            data_next.rem  = ge ? diff[42:0] : r2[42:0];
            data_next.root = {cur[k].root[39:0], ge};
            data_next.dsh  = {cur[k].dsh[31:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= cur_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                data_reg[k+1] <= data_next;
            end
        end
    end

    assign out_valid = vld_reg[qrs_pkg::SqrtSteps];
    assign out_data  = data_reg[qrs_pkg::SqrtSteps];

endmodule

FILE: hw/rtl/qrs_div_pipe.sv
// Pipelined restoring divider with two lanes sharing one divisor.
// Depends on qrs_pkg.
module qrs_div_pipe
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  qrs_pkg::div_t in_data,
    output logic          out_valid,
    output qrs_pkg::div_t out_data
);

    qrs_pkg::div_t data_reg [1:qrs_pkg::DivSteps];
    logic          vld_reg  [1:qrs_pkg::DivSteps];
    qrs_pkg::div_t cur      [0:qrs_pkg::DivSteps-1];
    logic          cur_vld  [0:qrs_pkg::DivSteps-1];

    function automatic qrs_pkg::lane_t lane_step(qrs_pkg::lane_t l, logic [24:0] dv);
        logic [25:0]    r2;
        logic [25:0]    diff;
        logic           ge;
        qrs_pkg::lane_t o;
        r2   = {l.rem, l.low[33]};
        diff = r2 - {1'b0, dv};
        ge   = (r2 >= {1'b0, dv});
        o      = l;
        o.rem  = ge ? diff[24:0] : r2[24:0];
        o.low  = {l.low[32:0], 1'b0};
        o.quo  = {l.quo[32:0], ge};
        return o;
    endfunction

    for (genvar k = 0; k < qrs_pkg::DivSteps; k++)
    begin : g_step
        qrs_pkg::div_t data_next;

        if (k == 0)
        begin : g_first
            assign cur[k]     = in_data;
            assign cur_vld[k] = in_valid;
        end
        else
        begin : g_rest
            assign cur[k]     = data_reg[k];
            assign cur_vld[k] = vld_reg[k];
        end

        always_comb
        begin
            data_next    = cur[k];
            data_next.lp = lane_step(cur[k].lp, cur[k].divisor);
            data_next.lm = lane_step(cur[k].lm, cur[k].divisor);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= cur_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                data_reg[k+1] <= data_next;
            end
        end
    end

    assign out_valid = vld_reg[qrs_pkg::DivSteps];
    assign out_data  = data_reg[qrs_pkg::DivSteps];

endmodule

FILE: hw/rtl/quadratic_root_solver.sv
// The result passes through 80 register stages (input, product, discriminant,
// 41 square-root steps, numerator, 34 divide steps, output register).
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset clears every valid bit asynchronously; data registers are not reset.
`include "assert_macros.svh"
module quadratic_root_solver
(
    input  logic         clk,
    input  logic         rst_n,
    qrs_in_if.sink       coef,
    qrs_out_if.source    root
);

    logic en;

    // Input stage.
    logic               s0_vld_reg;
    logic signed [15:0] s0_quad_reg;
    logic signed [15:0] s0_lin_reg;
    logic signed [15:0] s0_const_reg;

    // Product stage.
    logic               s1_vld_reg;
    logic signed [31:0] s1_bb_reg;
    logic signed [31:0] s1_ac_reg;
    logic signed [15:0] s1_quad_reg;
    logic signed [15:0] s1_lin_reg;

    // Discriminant stage.
    logic               s2_vld_reg;
    qrs_pkg::sqrt_t     s2_data_reg;
    logic signed [34:0] disc;
    logic [1:0]         kind_next;

    logic               sq_vld;
    qrs_pkg::sqrt_t     sq_data;

    // Numerator stage.
    logic               s3_vld_reg;
    qrs_pkg::div_t      s3_data_reg;
    qrs_pkg::div_t      s3_next;
    logic signed [16:0] neg_b;
    logic signed [42:0] base;
    logic signed [42:0] num_p;
    logic signed [42:0] num_m;
    logic [42:0]        mag_p;
    logic [42:0]        mag_m;
    logic [15:0]        mag_a;
    logic [24:0]        mag_q;
    logic [42:0]        div_p;
    logic [42:0]        div_m;

    logic               dv_vld;
    qrs_pkg::div_t      dv_data;

    // Output register.
    logic               out_vld_reg;
    logic [1:0]         kind_reg;
    logic signed [39:0] plus_reg;
    logic signed [39:0] minus_reg;
    logic signed [39:0] plus_next;
    logic signed [39:0] minus_next;

    assign en         = !out_vld_reg || root.ready;
    assign coef.ready = en;

    always_comb
    begin
        disc = {{3{s1_bb_reg[31]}}, s1_bb_reg} - {s1_ac_reg[31], s1_ac_reg, 2'b00};
        if (s1_quad_reg == 16'sd0)
        begin
            kind_next = qrs_pkg::KindNotQuad;
        end
        else if (disc[34])
        begin
            kind_next = qrs_pkg::KindNoReal;
        end
        else if (disc == 35'sd0)
        begin
            kind_next = qrs_pkg::KindSingle;
        end
        else
        begin
            kind_next = qrs_pkg::KindTwo;
        end
    end

    always_comb
    begin
        neg_b = -{sq_data.side.lin[15], sq_data.side.lin};
        base  = {{2{neg_b[16]}}, neg_b, 24'd0};
        num_p = base + {2'b00, sq_data.root};
        num_m = base - {2'b00, sq_data.root};
        mag_p = num_p[42] ? -num_p : num_p;
        mag_m = num_m[42] ? -num_m : num_m;
        mag_a = sq_data.side.quad[15] ? 16'(-sq_data.side.quad) : 16'(sq_data.side.quad);
        mag_q = {mag_a, 9'd0};
        // Adding half the divisor turns the truncating divide into round-half-away.
        div_p = mag_p + {18'd0, 1'b0, mag_q[24:1]};
        div_m = mag_m + {18'd0, 1'b0, mag_q[24:1]};
        s3_next.kind       = sq_data.side.kind;
        s3_next.divisor    = mag_q;
        s3_next.lp.rem     = {16'd0, div_p[42:34]};
        s3_next.lp.low     = div_p[33:0];
        s3_next.lp.quo     = '0;
        s3_next.lp.neg     = num_p[42] ^ sq_data.side.quad[15];
        s3_next.lm.rem     = {16'd0, div_m[42:34]};
        s3_next.lm.low     = div_m[33:0];
        s3_next.lm.quo     = '0;
        s3_next.lm.neg     = num_m[42] ^ sq_data.side.quad[15];
    end

    always_comb
    begin
        plus_next  = '0;
        minus_next = '0;
        if (dv_data.kind == qrs_pkg::KindSingle || dv_data.kind == qrs_pkg::KindTwo)
        begin
            plus_next = dv_data.lp.neg ? -$signed({6'd0, dv_data.lp.quo})
                                       : $signed({6'd0, dv_data.lp.quo});
        end
        if (dv_data.kind == qrs_pkg::KindTwo)
        begin
            minus_next = dv_data.lm.neg ? -$signed({6'd0, dv_data.lm.quo})
                                        : $signed({6'd0, dv_data.lm.quo});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg  <= coef.valid;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= sq_vld;
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_quad_reg  <= coef.coef_quad;
            s0_lin_reg   <= coef.coef_lin;
            s0_const_reg <= coef.coef_const;
            s1_bb_reg    <= s0_lin_reg * s0_lin_reg;
            s1_ac_reg    <= s0_quad_reg * s0_const_reg;
            s1_quad_reg  <= s0_quad_reg;
            s1_lin_reg   <= s0_lin_reg;
            s2_data_reg.rem       <= '0;
            s2_data_reg.root      <= '0;
            s2_data_reg.dsh       <= (kind_next == qrs_pkg::KindTwo) ? disc[33:0] : 34'd0;
            s2_data_reg.side.kind <= kind_next;
            s2_data_reg.side.quad <= s1_quad_reg;
            s2_data_reg.side.lin  <= s1_lin_reg;
            s3_data_reg <= s3_next;
            kind_reg    <= dv_data.kind;
            plus_reg    <= plus_next;
            minus_reg   <= minus_next;
        end
    end

    qrs_sqrt_pipe u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .in_data   (s2_data_reg),
        .out_valid (sq_vld),
        .out_data  (sq_data)
    );

    qrs_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .in_data   (s3_data_reg),
        .out_valid (dv_vld),
        .out_data  (dv_data)
    );

    assign root.valid      = out_vld_reg;
    assign root.root_kind  = kind_reg;
    assign root.root_plus  = plus_reg;
    assign root.root_minus = minus_reg;

    `ASSERT_IMPLIES(a_stall_blocks_input, out_vld_reg && !root.ready, !coef.ready)
    `ASSERT_IMPLIES(a_no_root_zero,
        out_vld_reg && (kind_reg == qrs_pkg::KindNotQuad || kind_reg == qrs_pkg::KindNoReal),
        plus_reg == 40'sd0 && minus_reg == 40'sd0)
    `ASSERT_IMPLIES(a_minus_only_two, out_vld_reg && kind_reg != qrs_pkg::KindTwo,
        minus_reg == 40'sd0)

endmodule

FILE: bench/quadratic_root_solver_tb.sv
// Self-checking testbench for the quadratic root solver.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if and quadratic_root_solver.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [39:0] plus;
        logic signed [39:0] minus;
    } roots_t;

    // Holds the roots predicted for accepted requests and checks results in order.
    class root_scoreboard;
        roots_t pending[$];
        int     errors;

        // floor(sqrt(d * 2^48)), digit by digit.
        function longint unsigned scaled_sqrt(longint unsigned d);
            longint unsigned r, rm, pair, trial;
            r = 0;
            rm = 0;
            for (int i = 0; i < 41; i++)
            begin
                pair = (i < 17) ? ((d >> (2 * (16 - i))) & 3) : 0;
                rm = (rm << 2) | pair;
                trial = (r << 2) | 1;
                r = r << 1;
                if (rm >= trial)
                begin
                    rm = rm - trial;
                    r = r | 1;
                end
            end
            return r;
        endfunction

        // Rounded to nearest, ties away from zero.
        function longint round_quot(longint num, longint den);
            longint unsigned an, ad, q;
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q = (an + ad / 2) / ad;
            return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function void note_request(logic signed [15:0] qa, logic signed [15:0] lb,
                                   logic signed [15:0] kc);
            roots_t e;
            longint a, b, c, disc, den, base, s;
            a = qa;
            b = lb;
            c = kc;
            disc = b * b - 4 * a * c;
            e = '0;
            if (a == 0)
                e.kind = qrs_pkg::KindNotQuad;
            else if (disc < 0)
                e.kind = qrs_pkg::KindNoReal;
            else
            begin
                den = a * 512;
                base = -b * (longint'(1) << 24);
                if (disc == 0)
                begin
                    e.kind = qrs_pkg::KindSingle;
                    e.plus = 40'(round_quot(base, den));
                end
                else
                begin
                    s = longint'(scaled_sqrt(disc));
                    e.kind = qrs_pkg::KindTwo;
                    e.plus = 40'(round_quot(base + s, den));
                    e.minus = 40'(round_quot(base - s, den));
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(roots_t got);
            roots_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d", $time, got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind)
            begin
                $display("%0t: root_kind expected %0d actual %0d", $time, e.kind, got.kind);
                errors++;
            end
            if (got.plus !== e.plus)
            begin
                $display("%0t: root_plus expected %0d actual %0d", $time, e.plus, got.plus);
                errors++;
            end
            if (got.minus !== e.minus)
            begin
                $display("%0t: root_minus expected %0d actual %0d", $time, e.minus,
                         got.minus);
                errors++;
            end
        endfunction
    endclass

    localparam int Latency = 80;
    localparam int StallLimit = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   idle_pct = 29;
    bit   stim_done = 1'b0;
    int   quiet_cycles = 0;

    root_scoreboard roots_sb;

    qrs_in_if  coef ();
    qrs_out_if root ();

    quadratic_root_solver u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef.sink),
        .root  (root.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        coef.valid = 1'b0;
        coef.coef_quad = '0;
        coef.coef_lin = '0;
        coef.coef_const = '0;
        root.ready = 1'b0;
        roots_sb = new();
    end

    // Sends one request, idling first at random, and waits for its acceptance.
    task automatic send_request(logic signed [15:0] qa, logic signed [15:0] lb,
                                logic signed [15:0] kc);
        while ($urandom_range(99) < idle_pct)
        begin
            coef.valid <= 1'b0;
            @(posedge clk);
        end
        coef.valid <= 1'b1;
        coef.coef_quad <= qa;
        coef.coef_lin <= lb;
        coef.coef_const <= kc;
        @(posedge clk);
        while (!coef.ready)
            @(posedge clk);
    endtask

    // Picks a coefficient, biased toward the extremes and small values.
    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(16)) - 8);
            3: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] qa, lb, kc;
        int r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: not quadratic, no real root, single root, two roots, extremes.
        send_request(16'sd0, 16'sd256, 16'sd512);
        send_request(16'sd0, 16'sd0, 16'sd0);
        send_request(16'sd256, 16'sd0, 16'sd256);
        send_request(16'sd256, 16'sd512, 16'sd256);
        send_request(16'sd256, -16'sd512, 16'sd256);
        send_request(-16'sd256, 16'sd0, 16'sd256);
        send_request(16'sd256, 16'sd0, -16'sd256);
        send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_request(16'sh8000, 16'sh8000, 16'sh8000);
        send_request(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_request(16'sh7fff, 16'sh8000, 16'sh8000);
        send_request(16'sd1, 16'sh8000, 16'sh7fff);
        send_request(-16'sd1, 16'sh7fff, 16'sh7fff);
        send_request(16'sd1, 16'sd0, 16'sd0);
        send_request(16'sh8000, 16'sd0, 16'sd0);
        send_request(16'sd1, 16'sd1, 16'sd0);
        send_request(16'sd1, 16'sd2, 16'sd1);
        send_request(-16'sd1, -16'sd1, 16'sd0);
        send_request(16'sh7fff, 16'sd0, 16'sh7fff);
        send_request(16'sd4, 16'sd4, 16'sd1);
        for (int i = 0; i < 1750; i++)
        begin
            idle_pct = (i >= 600 && i < 900) ? 0 : 29;
            qa = pick_coef();
            lb = pick_coef();
            kc = pick_coef();
            // A share of the requests is built to have a double root: c = b^2 / 4a.
            r = $urandom_range(9);
            if (r == 0)
            begin
                qa = 16'($signed($urandom_range(15)) - 8);
                if (qa == 0)
                    qa = 16'sd1;
                lb = 16'(2 * qa * ($signed($urandom_range(40)) - 20));
                kc = 16'((lb * lb) / (4 * qa));
            end
            send_request(qa, lb, kc);
        end
        coef.valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (coef.valid && coef.ready)
            roots_sb.note_request(coef.coef_quad, coef.coef_lin, coef.coef_const);
        if (root.valid && root.ready)
            roots_sb.check_result({root.root_kind, root.root_plus, root.root_minus});
        if ((coef.valid && coef.ready) || (root.valid && root.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n)
            root.ready <= ($urandom_range(99) >= idle_pct);
    end

    initial
    begin
        wait (stim_done);
        while (roots_sb.pending.size() != 0 && quiet_cycles < StallLimit)
            @(posedge clk);
        repeat (Latency + 20) @(posedge clk);
        if (roots_sb.pending.size() == 0 && roots_sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= StallLimit && !stim_done)
        begin
            $display("%0t: no request or result accepted for too long", $time);
            $display("testbench NOT OK");
            $finish;
        end
    end
endmodule
